[sv/sensor_frame_checker_with_history_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame checker
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECKER_WITH_HISTORY_ASSERT_SVH
`define SENSOR_FRAME_CHECKER_WITH_HISTORY_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold in the same cycle.
`define SFC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property whose consequence must hold in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SFC_ASSERT(lbl, clk, rstn, prop, msg)
`define SFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[sv/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker package
// Shared constants, codes and types of the frame checker and its history.
// ----------------------------------------------------------------------------
package sfc_pkg;

	// Default history depth and the fixed width of one stored reading.
	localparam int HISTORY_DEPTH_DEF = 36;
	localparam int READING_W         = 16;
	localparam int ERR_W             = 3;

	// Frame format.
	localparam logic [7:0] HDR0          = 8'h16;
	localparam logic [7:0] HDR1          = 8'h0D;
	localparam logic [7:0] HDR2          = 8'h01;
	localparam int         MIN_FRAME_LEN = 16;

	// Byte positions of interest inside a frame.
	localparam logic [7:0] POS_HDR0    = 8'd0;
	localparam logic [7:0] POS_HDR1    = 8'd1;
	localparam logic [7:0] POS_HDR2    = 8'd2;
	localparam logic [7:0] POS_RD_HIGH = 8'd3;
	localparam logic [7:0] POS_RD_LOW  = 8'd4;
	localparam logic [7:0] POS_MAX     = 8'd255;

	// Input modes.
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Result kinds.
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	// Verdict error codes.
	localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_HEADER    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_CHECKSUM  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd3;
	localparam logic [ERR_W-1:0] ERR_NO_EARLIER = 3'd4;

	typedef logic [READING_W-1:0] reading_t;

	// Verdict of a finished frame, handed from the frame parser to the top.
	typedef struct packed {
		logic             valid;
		logic             push;
		logic [ERR_W-1:0] err;
		reading_t         rd;
	} verdict_t;

endpackage

[sv/sfc_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel of the sensor frame checker
// Valid/ready channel that carries one frame byte or one history read request.
// ----------------------------------------------------------------------------
interface sfc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;
	logic       frame_end;
	logic [5:0] history_index;

	modport source (output valid, output mode, output data_byte, output frame_end,
		output history_index, input ready);
	modport sink (input valid, input mode, input data_byte, input frame_end,
		input history_index, output ready);
endinterface

[sv/sfc_out_if.sv]
// ----------------------------------------------------------------------------
// Output channel of the sensor frame checker
// Valid/ready channel that carries a frame verdict or a history read answer.
// ----------------------------------------------------------------------------
interface sfc_out_if #(
	parameter int FILL_W = 6
);
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [2:0]        error_code;
	logic [15:0]       reading;
	logic [FILL_W-1:0] history_fill;
	logic [15:0]       history_value;

	modport source (output valid, output result_kind, output error_code, output reading,
		output history_fill, output history_value, input ready);
	modport sink (input valid, input result_kind, input error_code, input reading,
		input history_fill, input history_value, output ready);
endinterface

[sv/sfc_hist_cell.sv]
// ----------------------------------------------------------------------------
// History cell
// Holds one reading, takes its left neighbor's value on a push and drives its
// value onto the read bus when it is the selected cell.
// ----------------------------------------------------------------------------
module sfc_hist_cell (
	input  logic              clk,
	input  logic              shift,
	input  sfc_pkg::reading_t value_in,
	input  logic              hit,
	output sfc_pkg::reading_t value_out,
	output sfc_pkg::reading_t read_out
);
	import sfc_pkg::*;

	reading_t value_q;

	// Shift in the neighbor's value on every push.
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= value_in;
		end
	end

	assign value_out = value_q;
	assign read_out  = hit ? value_q : '0;

endmodule

[sv/sfc_frame.sv]
// ----------------------------------------------------------------------------
// Frame parser
// Tracks position, byte sum, header and reading of the frame in progress and
// forms the verdict when the final byte arrives.
// ----------------------------------------------------------------------------
module sfc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_go,
	input  logic [7:0]        data_byte,
	input  logic              frame_end,
	output sfc_pkg::verdict_t verdict
);
	import sfc_pkg::*;

	logic [7:0] pos_q;
	logic [7:0] sum_q;
	logic       hdr_ok_q;
	reading_t   capture_q;
	reading_t   last_q;

	logic       fin;
	logic [7:0] expect_sum;
	reading_t   rd_sel;
	logic       hdr_ok_next;

	assign fin        = byte_go && frame_end;
	assign expect_sum = 8'(8'd0 - sum_q);
	assign rd_sel     = (capture_q != '0) ? capture_q : last_q;

	// Header check of the current byte.
	always_comb begin
		hdr_ok_next = hdr_ok_q;
		if (pos_q == POS_HDR0 && data_byte != HDR0) hdr_ok_next = 1'b0;
		if (pos_q == POS_HDR1 && data_byte != HDR1) hdr_ok_next = 1'b0;
		if (pos_q == POS_HDR2 && data_byte != HDR2) hdr_ok_next = 1'b0;
	end

	// Verdict on the final byte; too short wins over header, header over checksum.
	always_comb begin
		verdict.valid = fin;
		verdict.push  = 1'b0;
		verdict.rd    = '0;
		if (pos_q < 8'(MIN_FRAME_LEN - 1)) begin
			verdict.err = ERR_SHORT;
		end else if (!hdr_ok_q) begin
			verdict.err = ERR_HEADER;
		end else if (data_byte != expect_sum) begin
			verdict.err = ERR_CHECKSUM;
		end else if (rd_sel == '0) begin
			verdict.err = ERR_NO_EARLIER;
		end else begin
			verdict.err  = ERR_OK;
			verdict.push = fin;
			verdict.rd   = rd_sel;
		end
	end

	// Frame state; the final byte returns it to the reset values, but for the last reading, which a push updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			hdr_ok_q  <= 1'b1;
			capture_q <= '0;
			last_q    <= '0;
		end else if (fin) begin
			pos_q     <= '0;
			sum_q     <= '0;
			hdr_ok_q  <= 1'b1;
			capture_q <= '0;
			if (verdict.push) begin
				last_q <= rd_sel;
			end
		end else if (byte_go) begin
			hdr_ok_q <= hdr_ok_next;
			sum_q    <= 8'(sum_q + data_byte);
			if (pos_q != POS_MAX) begin
				pos_q <= 8'(pos_q + 8'd1);
			end
			if (pos_q == POS_RD_HIGH) begin
				capture_q[15:8] <= data_byte;
			end
			if (pos_q == POS_RD_LOW) begin
				capture_q[7:0] <= data_byte;
			end
		end
	end

endmodule

[sv/sensor_frame_checker_with_history.sv]
// A result is registered and shown in the cycle after its transaction.
// Throughput: one transaction per cycle, a frame byte or a history read alike, while the receiver takes each result.
// A read answer reflects every frame verdict accepted before it.
// History is a row of shifting cells; a push moves every cell together.
// Reset clears the frame state, the last reading and the fill count at once;
// cell contents stay undefined and are only read below the fill count.
// ----------------------------------------------------------------------------
// Sensor frame checker with history
// Checks received sensor frames, keeps a history of accepted readings and
// answers read requests for history entries.
// ----------------------------------------------------------------------------
`include "sensor_frame_checker_with_history_assert.svh"

module sensor_frame_checker_with_history #(
	parameter int HISTORY_DEPTH = sfc_pkg::HISTORY_DEPTH_DEF
) (
	input logic   clk,
	input logic   arst_n,
	sfc_in_if.sink  in_ch,
	sfc_out_if.source out_ch
);
	import sfc_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

	logic             accept;
	logic             byte_go;
	logic             read_go;
	verdict_t         verdict;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             in_range;
	logic [IDX_W-1:0] target;
	reading_t         cell_val [HISTORY_DEPTH];
	reading_t         cell_rd  [HISTORY_DEPTH];
	reading_t         read_value;

	logic             ovalid_q;
	logic             kind_q;
	logic [ERR_W-1:0] err_q;
	reading_t         rd_q;
	logic [CNT_W-1:0] fill_q;
	reading_t         hval_q;

	// Handshake: the output register frees whenever its content is taken.
	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign byte_go     = accept && (in_ch.mode == MODE_BYTE);
	assign read_go     = accept && (in_ch.mode == MODE_READ);

	sfc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_go   (byte_go),
		.data_byte (in_ch.data_byte),
		.frame_end (in_ch.frame_end),
		.verdict   (verdict)
	);

	// Fill count grows until the history is full; then the oldest cell drops out.
	assign count_next = (verdict.push && count_q != CNT_W'(HISTORY_DEPTH)) ?
		CNT_W'(count_q + 1'b1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Newest entry sits in cell 0, so index i (0 = oldest) lives in cell count-1-i.
	assign in_range = CMP_W'(in_ch.history_index) < CMP_W'(count_q);
	assign target   = IDX_W'(CMP_W'(count_q) - CMP_W'(1) - CMP_W'(in_ch.history_index));

	// Row of history cells.
	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
		sfc_hist_cell u_cell (
			.clk       (clk),
			.shift     (verdict.push),
			.value_in  ((k == 0) ? verdict.rd : cell_val[(k == 0) ? 0 : k - 1]),
			.hit       (in_range && target == IDX_W'(k)),
			.value_out (cell_val[k]),
			.read_out  (cell_rd[k])
		);
	end

	// Read bus: at most one cell drives a nonzero value.
	always_comb begin
		read_value = '0;
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			read_value = read_value | cell_rd[k];
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (read_go || verdict.valid) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (read_go) begin
			kind_q <= KIND_READ;
			err_q  <= ERR_OK;
			rd_q   <= '0;
			fill_q <= count_q;
			hval_q <= read_value;
		end else if (verdict.valid) begin
			kind_q <= KIND_VERDICT;
			err_q  <= verdict.err;
			rd_q   <= verdict.rd;
			fill_q <= count_next;
			hval_q <= '0;
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.result_kind   = kind_q;
	assign out_ch.error_code    = err_q;
	assign out_ch.reading       = rd_q;
	assign out_ch.history_fill  = fill_q;
	assign out_ch.history_value = hval_q;

	// Checks.
	`SFC_ASSERT(a_fill_bound, clk, arst_n, count_q <= CNT_W'(HISTORY_DEPTH), "history fill above depth")
	`SFC_ASSERT_NEXT(a_full_stays, clk, arst_n, verdict.push && count_q == CNT_W'(HISTORY_DEPTH), count_q == CNT_W'(HISTORY_DEPTH), "push on full history changed the fill")
	`SFC_ASSERT(a_reject_zero, clk, arst_n, !ovalid_q || err_q == ERR_OK || rd_q == '0, "rejected verdict carries a reading")
	`SFC_ASSERT(a_read_clean, clk, arst_n, !ovalid_q || kind_q == KIND_VERDICT || (err_q == ERR_OK && rd_q == '0), "read answer carries verdict fields")
	`SFC_ASSERT_NEXT(a_accept_shows, clk, arst_n, accept && (read_go || in_ch.frame_end), ovalid_q, "result not registered after its transaction")

endmodule

[bench/tb_sensor_frame_checker_with_history.sv]
// ----------------------------------------------------------------------------
// Testbench of the sensor frame checker with history
// Streams frame bytes and history read requests into the checker and compares
// every verdict and read answer with a cycle-free behavioral model of the
// block. Both channels idle at random. Once the receiver holds off long
// enough to back up the input, and the sender twice waits for all answers.
// ----------------------------------------------------------------------------
module tb_sensor_frame_checker_with_history;
	import sfc_pkg::*;

	localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int BACKLOG_CYCLES = 300;

	// One input transaction, plus a marker that makes the sender wait for
	// every outstanding answer before it goes on.
	typedef struct {
		logic       mode;
		logic [7:0] data_byte;
		logic       frame_end;
		logic [5:0] history_index;
		bit         drain_first;
	} sensor_txn_t;

	// One output transaction.
	typedef struct packed {
		logic       kind;
		logic [2:0] err;
		logic [15:0] rd;
		logic [5:0] fill;
		logic [15:0] value;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	sfc_in_if  in_ch ();
	sfc_out_if out_ch ();

	sensor_frame_checker_with_history dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Stimulus waiting to be sent and answers waiting to arrive.
	sensor_txn_t stim_q[$];
	answer_t     answer_q[$];
	int          answers_owed    = 0;
	int          answers_checked = 0;
	bit          failed          = 1'b0;

	// Behavioral copy of the frame parser and the reading history.
	logic [7:0]  frame_pos;
	logic [7:0]  frame_sum;
	logic        hdr_ok;
	logic [15:0] capture;
	logic [15:0] last_good;
	logic [15:0] hist_cells [HIST_DEPTH];
	int          hist_fill;
	int          hist_oldest;

	// Timing of both sides.
	logic [31:0] cycle_no = '0;
	int          idle_cycles = 0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          backlog_left = 0;
	bit          backlog_done = 1'b0;
	logic        calm;

	assign calm = (cycle_no[9:8] == 2'd0);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int gap_len(input logic no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Clear the frame in progress.
	function automatic void frame_restart();
		frame_pos = '0;
		frame_sum = '0;
		hdr_ok    = 1'b1;
		capture   = '0;
	endfunction

	// Apply one accepted transaction to the model; returns 1 when it yields an answer.
	function automatic bit sensor_step(input sensor_txn_t t, output answer_t a);
		logic [2:0]  err;
		logic [15:0] rd;
		a = '0;
		if (t.mode == MODE_READ) begin
			a.kind = KIND_READ;
			a.fill = 6'(hist_fill);
			if (int'(t.history_index) < hist_fill)
				a.value = hist_cells[(hist_oldest + int'(t.history_index)) % HIST_DEPTH];
			return 1'b1;
		end
		// A byte that is not the last one only feeds the header check, the capture, the sum and the position.
		if (!t.frame_end) begin
			if (frame_pos == POS_HDR0 && t.data_byte != HDR0)
				hdr_ok = 1'b0;
			if (frame_pos == POS_HDR1 && t.data_byte != HDR1)
				hdr_ok = 1'b0;
			if (frame_pos == POS_HDR2 && t.data_byte != HDR2)
				hdr_ok = 1'b0;
			if (frame_pos == POS_RD_HIGH)
				capture[15:8] = t.data_byte;
			if (frame_pos == POS_RD_LOW)
				capture[7:0] = t.data_byte;
			frame_sum = frame_sum + t.data_byte;
			if (frame_pos != POS_MAX)
				frame_pos = frame_pos + 8'd1;
			return 1'b0;
		end
		// The checksum byte closes the frame; faults rank short, header, sum.
		err = ERR_OK;
		rd  = '0;
		if (int'(frame_pos) + 1 < MIN_FRAME_LEN) begin
			err = ERR_SHORT;
		end else if (!hdr_ok) begin
			err = ERR_HEADER;
		end else if (t.data_byte != 8'(-frame_sum)) begin
			err = ERR_CHECKSUM;
		end else begin
			rd = (capture != '0) ? capture : last_good;
			if (rd == '0) begin
				err = ERR_NO_EARLIER;
			end else begin
				last_good = rd;
				if (hist_fill < HIST_DEPTH) begin
					hist_cells[(hist_oldest + hist_fill) % HIST_DEPTH] = rd;
					hist_fill++;
				end else begin
					hist_cells[hist_oldest] = rd;
					hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
				end
			end
		end
		frame_restart();
		a.kind = KIND_VERDICT;
		a.err  = err;
		a.rd   = (err == ERR_OK) ? rd : '0;
		a.fill = 6'(hist_fill);
		return 1'b1;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic fend);
		sensor_txn_t t;
		t.mode          = MODE_BYTE;
		t.data_byte     = b;
		t.frame_end     = fend;
		t.history_index = 6'($urandom_range(0, 63));
		t.drain_first   = 1'b0;
		stim_q.push_back(t);
	endtask

	task automatic queue_read(input logic [5:0] idx);
		sensor_txn_t t;
		t.mode          = MODE_READ;
		t.data_byte     = 8'($urandom_range(0, 255));
		t.frame_end     = 1'($urandom_range(0, 1));
		t.history_index = idx;
		t.drain_first   = 1'b0;
		stim_q.push_back(t);
	endtask

	task automatic queue_drain();
		sensor_txn_t t;
		t = '{MODE_BYTE, 8'd0, 1'b0, 6'd0, 1'b1};
		stim_q.push_back(t);
	endtask

	// Read index: mostly inside the history range, sometimes anywhere.
	function automatic logic [5:0] pick_index();
		if ($urandom_range(0, 3) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, HIST_DEPTH));
	endfunction

	// Build a frame of len bytes around a reading, optionally broken, with
	// history reads slipped in between its bytes.
	task automatic queue_frame(input int len, input logic [15:0] rd, input bit hdr_bad,
		input bit sum_bad, input int read_pct);
		logic [7:0] body[$];
		logic [7:0] sum;
		int         k;
		body = {HDR0, HDR1, HDR2, rd[15:8], rd[7:0]};
		while (body.size() < len - 1)
			body.push_back(8'($urandom_range(0, 255)));
		while (body.size() > len - 1)
			void'(body.pop_back());
		if (hdr_bad && body.size() > 0) begin
			k = $urandom_range(0, ((body.size() < 3) ? body.size() : 3) - 1);
			body[k] = body[k] ^ 8'($urandom_range(1, 255));
		end
		sum = '0;
		foreach (body[i])
			sum = sum + body[i];
		sum = -sum;
		if (sum_bad)
			sum = sum ^ 8'($urandom_range(1, 255));
		body.push_back(sum);
		foreach (body[i]) begin
			if ($urandom_range(0, 99) < read_pct)
				queue_read(pick_index());
			queue_byte(body[i], i == body.size() - 1);
		end
	endtask

	function automatic logic [15:0] pick_reading();
		case ($urandom_range(0, 7))
			0: return 16'hFFFF;
			1: return 16'h0001;
			2: return 16'h8000;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// Sender: offers queued transactions, with random gaps between them.
	always @(posedge clk) begin : sender
		sensor_txn_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (stim_q.size() != 0 && stim_q[0].drain_first) begin
				in_ch.valid <= 1'b0;
				if (!in_ch.valid && answers_owed == 0)
					void'(stim_q.pop_front());
			end else if (stim_q.size() != 0) begin
				nxt = stim_q.pop_front();
				in_ch.valid         <= 1'b1;
				in_ch.mode          <= nxt.mode;
				in_ch.data_byte     <= nxt.data_byte;
				in_ch.frame_end     <= nxt.frame_end;
				in_ch.history_index <= nxt.history_index;
				send_gap <= gap_len(calm);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, and once a long hold-off that backs up the input.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (backlog_left > 0) begin
			backlog_left <= backlog_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!backlog_done && answers_checked >= 40) begin
			backlog_done <= 1'b1;
			backlog_left <= BACKLOG_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			out_ch.ready <= 1'b0;
		end else begin : pick_stall
			int g;
			g = gap_len(calm);
			out_ch.ready <= (g == 0);
			recv_stall <= (g > 0) ? g - 1 : 0;
		end
	end

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	// Monitor: checks each answer against the oldest prediction, then predicts
	// from the transaction accepted at the same edge.
	always @(posedge clk) begin : monitor
		sensor_txn_t t;
		answer_t     got;
		answer_t     want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.result_kind, out_ch.error_code, out_ch.reading,
					out_ch.history_fill, out_ch.history_value};
				if (answer_q.size() == 0) begin
					$display("%0t: no answer expected, actual %0h", $time, got);
					failed = 1'b1;
				end else begin
					want = answer_q.pop_front();
					compare_field("result_kind", want.kind, got.kind);
					compare_field("error_code", want.err, got.err);
					compare_field("reading", want.rd, got.rd);
					compare_field("history_fill", want.fill, got.fill);
					compare_field("history_value", want.value, got.value);
				end
				answers_checked <= answers_checked + 1;
			end
			if (in_ch.valid && in_ch.ready) begin
				t = '{in_ch.mode, in_ch.data_byte, in_ch.frame_end, in_ch.history_index, 1'b0};
				if (sensor_step(t, want))
					answer_q.push_back(want);
			end
			answers_owed <= answer_q.size();
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 32'd1;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sensor_frame_checker_with_history: mismatch");
			$finish;
		end
	end

	initial begin
		int pick;
		int len;
		int n;
		int start_size;
		bit drained;
		bit overlong_sent;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.mode          = MODE_BYTE;
		in_ch.data_byte     = '0;
		in_ch.frame_end     = 1'b0;
		in_ch.history_index = '0;
		out_ch.ready        = 1'b0;
		frame_restart();
		last_good   = '0;
		hist_fill   = 0;
		hist_oldest = 0;

		// Directed: reads of an empty history, a one-byte frame, and a zero
		// reading before any reading was accepted.
		queue_read(6'd0);
		queue_read(6'd63);
		queue_byte(HDR0, 1'b1);
		queue_frame(MIN_FRAME_LEN, 16'h0000, 1'b0, 1'b0, 0);
		queue_drain();

		// Random: mostly well-formed frames, with broken frames, noise and reads.
		start_size    = stim_q.size();
		drained       = 1'b0;
		overlong_sent = 1'b0;
		while (stim_q.size() - start_size < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_FRAME_LEN, 24)
				: MIN_FRAME_LEN;
			if (pick < 58) begin
				queue_frame(len, pick_reading(), 1'b0, 1'b0, 4);
			end else if (pick < 66) begin
				queue_frame(len, 16'h0000, 1'b0, 1'b0, 4);
			end else if (pick < 73) begin
				queue_frame(len, pick_reading(), 1'b1, 1'($urandom_range(0, 1)), 4);
			end else if (pick < 80) begin
				queue_frame(len, pick_reading(), 1'b0, 1'b1, 4);
			end else if (pick < 88) begin
				queue_frame($urandom_range(1, MIN_FRAME_LEN - 1), pick_reading(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4);
			end else if (pick < 94) begin
				n = $urandom_range(1, 6);
				repeat (n)
					queue_read(pick_index());
			end else begin
				n = $urandom_range(1, 20);
				repeat (n)
					queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
			end
			if (!overlong_sent && stim_q.size() - start_size > RANDOM_ITEMS / 3) begin
				overlong_sent = 1'b1;
				queue_frame($urandom_range(256, 300), pick_reading(), 1'b0, 1'b0, 1);
			end
			if (!drained && stim_q.size() - start_size > RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				queue_drain();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the stimulus to drain and every answer to arrive.
		while (stim_q.size() != 0 || in_ch.valid || answers_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (answer_q.size() != 0) begin
			$display("%0t: %0d expected answers never arrived", $time, answer_q.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("sensor_frame_checker_with_history: match");
		else
			$display("sensor_frame_checker_with_history: mismatch");
		$finish;
	end

endmodule
